// ===== rtl/alu16_pkg.sv =====
// Shared types, operation codes and constants of the sixteen-bit ALU.
package alu16_pkg;

  localparam int unsigned FIELD_WIDTH  = 16;
  localparam int unsigned ACTION_WIDTH = 3;
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned DIV_BITS     = 4;
  localparam int unsigned INSERT_SHIFT = 8;
  localparam logic [FIELD_WIDTH-1:0] DIVISOR_ONE = 16'h0001;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_LSHF = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } action_e;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] action;
    logic [FIELD_WIDTH-1:0]  operand_a;
    logic [FIELD_WIDTH-1:0]  operand_b;
  } alu16_req_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] result_value;
    logic                   set_zero_flag;
  } alu16_rsp_t;

endpackage

// ===== rtl/alu16_front.sv =====
// First pipeline stage: decode, simple operations, multiply and divider setup.
module alu16_front import alu16_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  alu16_req_t            in_req_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [DATA_WIDTH-1:0] out_dvd_o,
  output logic [DATA_WIDTH-1:0] out_dvs_o,
  output logic                  out_flag_o
);

  logic [DATA_WIDTH-1:0] op_a, op_b, prod, val;
  logic [DATA_WIDTH-1:0] dvd_d, dvs_d, dvd_q, dvs_q;
  logic                  flag_d, flag_q, valid_q;

  assign op_a = DATA_WIDTH'(in_req_i.operand_a);
  assign op_b = DATA_WIDTH'(in_req_i.operand_b);
  assign prod = op_a * op_b;

  // Non-divide results ride through the divider as val / 1.
  always_comb begin
    val    = '0;
    flag_d = 1'b0;
    dvd_d  = '0;
    dvs_d  = DATA_WIDTH'(DIVISOR_ONE);
    case (in_req_i.action)
      ACT_ADD: begin
        val    = op_a + op_b;
        flag_d = (op_a == '0) && (op_b == '0);
      end
      ACT_SUB: begin
        val    = (op_a < op_b) ? '0 : op_a - op_b;
        flag_d = (op_a <= op_b);
      end
      ACT_LSHF: begin
        val    = (op_a << INSERT_SHIFT) + op_b;
        flag_d = (val == '0);
      end
      ACT_MUL: begin
        val    = prod;
        flag_d = (op_a == '0) || (op_b == '0);
      end
      ACT_DIV: begin
        flag_d = (op_b == '0) || (op_a < op_b);
      end
      default: begin
        val    = '0;
        flag_d = 1'b0;
      end
    endcase
    if (in_req_i.action == ACT_DIV) begin
      // A zero divisor becomes 0 / 1 so the quotient comes out zero.
      dvd_d = (op_b == '0) ? '0 : op_a;
      dvs_d = (op_b == '0) ? DATA_WIDTH'(DIVISOR_ONE) : op_b;
    end else begin
      dvd_d = val;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dvd_q  <= dvd_d;
      dvs_q  <= dvs_d;
      flag_q <= flag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_dvd_o   = dvd_q;
  assign out_dvs_o   = dvs_q;
  assign out_flag_o  = flag_q;

endmodule

// ===== rtl/alu16_div_stage.sv =====
// One divider stage: up to DIV_BITS restoring-division steps and a pipeline register.
module alu16_div_stage import alu16_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned STAGE_IDX  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] in_dvd_i,
  input  logic [DATA_WIDTH-1:0] in_dvs_i,
  input  logic [DATA_WIDTH-1:0] in_rem_i,
  input  logic                  in_flag_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [DATA_WIDTH-1:0] out_dvd_o,
  output logic [DATA_WIDTH-1:0] out_dvs_o,
  output logic [DATA_WIDTH-1:0] out_rem_o,
  output logic                  out_flag_o
);

  logic [DATA_WIDTH-1:0] dvd_d, rem_d, dvd_q, dvs_q, rem_q;
  logic                  flag_q, valid_q;

  // Shift quotient bits into the dividend register as its top bits leave.
  always_comb begin
    logic [DATA_WIDTH:0] trial;
    trial = '0;
    rem_d = in_rem_i;
    dvd_d = in_dvd_i;
    for (int k = 0; k < DIV_BITS; k++) begin
      if (STAGE_IDX * DIV_BITS + k < DATA_WIDTH) begin
        trial = {rem_d, dvd_d[DATA_WIDTH-1]};
        dvd_d = {dvd_d[DATA_WIDTH-2:0], 1'b0};
        if (trial >= {1'b0, in_dvs_i}) begin
          trial    = trial - {1'b0, in_dvs_i};
          dvd_d[0] = 1'b1;
        end
        rem_d = trial[DATA_WIDTH-1:0];
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dvd_q  <= dvd_d;
      dvs_q  <= in_dvs_i;
      rem_q  <= rem_d;
      flag_q <= in_flag_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_dvd_o   = dvd_q;
  assign out_dvs_o   = dvs_q;
  assign out_rem_o   = rem_q;
  assign out_flag_o  = flag_q;

endmodule

// ===== rtl/alu16_add_sub_shift_mul_div_unit.sv =====
// Top level of the pipelined sixteen-bit ALU.
// The unit is the execution ALU of a small 16-bit processor. Each request carries an
// operation (add, subtract saturating at zero, shift-insert a << 8 plus b, multiply,
// unsigned divide) and two unsigned operands; each response carries the low result bits
// and a set-zero-flag bit, high when the full-precision result is zero or the divisor
// is zero; for shift-insert it is high when the low result bits are zero. A zero divisor
// yields result 0; unused operation codes yield 0 with the flag clear. The unit keeps no
// state between requests. It takes one request per cycle while the stages can advance
// and answers in order: the first stage decodes, runs the simple operations and the
// multiplier, and every later stage retires up to four quotient bits of a restoring
// divider. All operations travel the same stages. Each stage holds its own valid bit and
// takes a new request whenever it is empty or its successor moves, so bubbles close up
// and a held response never blocks the stages behind it until they are all full.
module alu16_add_sub_shift_mul_div_unit import alu16_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  alu16_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output alu16_rsp_t out_rsp_o
);

  localparam int unsigned NumDiv = (DATA_WIDTH + DIV_BITS - 1) / DIV_BITS;

  // Index 0 is the front stage output; index g + 1 is divider stage g output.
  logic                  valid [NumDiv+1];
  logic                  ready [NumDiv+1];
  logic [DATA_WIDTH-1:0] dvd   [NumDiv+1];
  logic [DATA_WIDTH-1:0] dvs   [NumDiv+1];
  logic [DATA_WIDTH-1:0] rem   [NumDiv+1];
  logic                  flag  [NumDiv+1];
  logic                  front_ready;

  // Start every division with a cleared partial remainder.
  assign rem[0] = '0;

  alu16_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .in_req_i    (in_req_i),
    .out_ready_i (ready[0]),
    .out_valid_o (valid[0]),
    .out_dvd_o   (dvd[0]),
    .out_dvs_o   (dvs[0]),
    .out_flag_o  (flag[0])
  );

  for (genvar g = 0; g < NumDiv; g++) begin : g_div
    alu16_div_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .STAGE_IDX  (g)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_ready_o  (ready[g]),
      .in_dvd_i    (dvd[g]),
      .in_dvs_i    (dvs[g]),
      .in_rem_i    (rem[g]),
      .in_flag_i   (flag[g]),
      .out_ready_i (ready[g+1]),
      .out_valid_o (valid[g+1]),
      .out_dvd_o   (dvd[g+1]),
      .out_dvs_o   (dvs[g+1]),
      .out_rem_o   (rem[g+1]),
      .out_flag_o  (flag[g+1])
    );
  end

  // Drain the last stage whenever the consumer does not hold the response.
  assign ready[NumDiv] = !out_stall_i;
  assign in_stall_o    = !front_ready;

  // The last stage's dividend register holds the finished quotient.
  assign out_valid_o             = valid[NumDiv];
  assign out_rsp_o.result_value  = FIELD_WIDTH'(dvd[NumDiv]);
  assign out_rsp_o.set_zero_flag = flag[NumDiv];

  // Stall the input only when every stage is full behind a held response.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline can still advance");

  // Restoring division keeps the partial remainder below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[NumDiv] |-> rem[NumDiv] < dvs[NumDiv])
    else $error("divider remainder not below divisor");

  // A set zero flag always comes with a zero result.
  a_flag_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.set_zero_flag |-> out_rsp_o.result_value == '0)
    else $error("zero flag set with a nonzero result");

endmodule
